@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands for the RTL in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk_i edge, off while rst_ni is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clk_i edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ sv/plsm_pkg.sv @@
// ----------------------------------------------------------------------------
// plsm_pkg
// Types, codes and constants of the process state list manager.
// ----------------------------------------------------------------------------
package plsm_pkg;

  localparam int unsigned POOL  = 16;
  localparam int unsigned IdW   = 5;               // ids 0..POOL, 0 = none
  localparam int unsigned AddrW = $clog2(POOL);    // id - 1
  localparam int unsigned CntW  = 5;

  // op codes
  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_KILL   = 2'd1;
  localparam logic [1:0] OP_WAIT   = 2'd2;

  // status codes
  localparam logic [1:0] ST_DONE       = 2'd0;
  localparam logic [1:0] ST_FREE_EMPTY = 2'd1;
  localparam logic [1:0] ST_NOT_READY  = 2'd2;

  // list tags
  localparam logic [1:0] TAG_FREE    = 2'd0;
  localparam logic [1:0] TAG_READY   = 2'd1;
  localparam logic [1:0] TAG_BLOCKED = 2'd2;

  typedef struct packed {
    logic [1:0]     op;
    logic [IdW-1:0] proc_id;
  } req_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [IdW-1:0]  granted_id;
    logic [CntW-1:0] free_len;
    logic [CntW-1:0] ready_len;
    logic [CntW-1:0] blocked_len;
  } rsp_t;

  function automatic logic id_ok(input logic [IdW-1:0] id);
    return (id != '0) && (id <= IdW'(POOL));
  endfunction

  function automatic logic [AddrW-1:0] id2addr(input logic [IdW-1:0] id);
    logic [IdW-1:0] a;
    a = id - IdW'(1);
    return a[AddrW-1:0];
  endfunction

  // Successor of each entry after reset: ascending chain, last entry ends it.
  function automatic logic [IdW-1:0] link_init(input logic [AddrW-1:0] addr);
    logic [IdW-1:0] id;
    id = IdW'(addr) + IdW'(1);
    return (id < IdW'(POOL)) ? id + IdW'(1) : '0;
  endfunction

endpackage

@@ sv/plsm_ram.sv @@
// ----------------------------------------------------------------------------
// plsm_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module plsm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/process_state_list_manager.sv @@
// ----------------------------------------------------------------------------
// process_state_list_manager
// Free / ready / blocked lists over a fixed pool of process ids.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid_i / in_stall_o / in_data_i) carries op and
//   proc_id. Response channel (out_valid_o / out_stall_i / out_data_o)
//   returns one beat per request: status, granted id and the three list
//   lengths after the operation.
//   One request is in flight at a time; in_stall_o is high from the beat
//   after acceptance until the response beat has been taken.
//   States from request beat to response valid:
//     rejected request or unused op : DONE
//     create                        : POP, UNLINK, LINK if ready list non-empty, DONE
//     kill / wait                   : SUCC, WALK over each ready entry before
//                                     the id (at most POOL), UNLINK, LINK if
//                                     the destination list is non-empty, DONE
//   The walk does one link-memory read per cycle.
//   The next request is taken the cycle after the response beat.
//   A stalled response holds its value. Reset puts all ids on the free list
//   in ascending order; the link memory needs no clearing pass, per-entry
//   valid bits stand in for the reset chain until an entry is written.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module process_state_list_manager (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  plsm_pkg::req_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output plsm_pkg::rsp_t  out_data_o
);

  localparam int unsigned IdW   = plsm_pkg::IdW;
  localparam int unsigned AddrW = plsm_pkg::AddrW;
  localparam int unsigned CntW  = plsm_pkg::CntW;
  localparam int unsigned POOL  = plsm_pkg::POOL;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_POP    = 7'b0000010,
    S_SUCC   = 7'b0000100,
    S_WALK   = 7'b0001000,
    S_UNLINK = 7'b0010000,
    S_LINK   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  state_e          state_q, state_d;
  logic [1:0]      op_q, op_d;
  logic [IdW-1:0]  cur_id_q, cur_id_d;
  logic [IdW-1:0]  succ_q, succ_d;
  logic [IdW-1:0]  walk_p_q, walk_p_d;
  logic [CntW-1:0] walk_cnt_q, walk_cnt_d;
  logic [1:0]      status_q, status_d;
  logic [IdW-1:0]  granted_q, granted_d;

  logic [IdW-1:0]  free_head_q, free_head_d, free_tail_q, free_tail_d;
  logic [IdW-1:0]  ready_head_q, ready_head_d, ready_tail_q, ready_tail_d;
  logic [IdW-1:0]  blk_head_q, blk_head_d, blk_tail_q, blk_tail_d;
  logic [CntW-1:0] free_cnt_q, free_cnt_d;
  logic [CntW-1:0] ready_cnt_q, ready_cnt_d;
  logic [CntW-1:0] blk_cnt_q, blk_cnt_d;

  logic [1:0]      tag_q [POOL];
  logic [1:0]      tag_d [POOL];
  logic [POOL-1:0] link_vld_q, link_vld_d;
  logic [AddrW-1:0] rd_addr_q, rd_addr_d;
  logic            rd_vld_q, rd_vld_d;

  // link memory port
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [IdW-1:0]   ram_wdata, ram_rdata, link_rd;

  // destination list of the current op
  logic [IdW-1:0] dst_head, dst_tail;
  logic           set_dst_head, set_dst_tail;

  plsm_ram #(
    .Width (IdW),
    .Depth (POOL)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Unwritten entries still hold the reset chain.
  assign link_rd = rd_vld_q ? ram_rdata : plsm_pkg::link_init(rd_addr_q);

  always_comb begin
    case (op_q)
      plsm_pkg::OP_CREATE: begin
        dst_head = ready_head_q;
        dst_tail = ready_tail_q;
      end
      plsm_pkg::OP_KILL: begin
        dst_head = free_head_q;
        dst_tail = free_tail_q;
      end
      default: begin
        dst_head = blk_head_q;
        dst_tail = blk_tail_q;
      end
    endcase
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    cur_id_d     = cur_id_q;
    succ_d       = succ_q;
    walk_p_d     = walk_p_q;
    walk_cnt_d   = walk_cnt_q;
    status_d     = status_q;
    granted_d    = granted_q;
    free_head_d  = free_head_q;
    free_tail_d  = free_tail_q;
    ready_head_d = ready_head_q;
    ready_tail_d = ready_tail_q;
    blk_head_d   = blk_head_q;
    blk_tail_d   = blk_tail_q;
    free_cnt_d   = free_cnt_q;
    ready_cnt_d  = ready_cnt_q;
    blk_cnt_d    = blk_cnt_q;
    tag_d        = tag_q;
    link_vld_d   = link_vld_q;
    rd_addr_d    = rd_addr_q;
    rd_vld_d     = rd_vld_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = '0;
    set_dst_head = 1'b0;
    set_dst_tail = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d      = in_data_i.op;
          cur_id_d  = in_data_i.proc_id;
          status_d  = plsm_pkg::ST_DONE;
          granted_d = '0;
          case (in_data_i.op)
            plsm_pkg::OP_CREATE: begin
              if (free_cnt_q == '0 || !plsm_pkg::id_ok(free_head_q)) begin
                status_d = plsm_pkg::ST_FREE_EMPTY;
                state_d  = S_DONE;
              end else begin
                cur_id_d  = free_head_q;
                ram_re    = 1'b1;
                ram_raddr = plsm_pkg::id2addr(free_head_q);
                state_d   = S_POP;
              end
            end
            plsm_pkg::OP_KILL, plsm_pkg::OP_WAIT: begin
              if (!plsm_pkg::id_ok(in_data_i.proc_id) ||
                  tag_q[plsm_pkg::id2addr(in_data_i.proc_id)] != plsm_pkg::TAG_READY) begin
                status_d = plsm_pkg::ST_NOT_READY;
                state_d  = S_DONE;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = plsm_pkg::id2addr(in_data_i.proc_id);
                state_d   = S_SUCC;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_POP: begin
        free_head_d = link_rd;
        if (link_rd == '0) begin
          free_tail_d = '0;
        end
        state_d = S_UNLINK;
      end

      S_SUCC: begin
        succ_d = link_rd;
        if (ready_head_q == cur_id_q) begin
          ready_head_d = link_rd;
          if (ready_tail_q == cur_id_q) begin
            ready_tail_d = '0;
          end
          state_d = S_UNLINK;
        end else if (!plsm_pkg::id_ok(ready_head_q)) begin
          state_d = S_UNLINK;
        end else begin
          walk_p_d   = ready_head_q;
          walk_cnt_d = '0;
          ram_re     = 1'b1;
          ram_raddr  = plsm_pkg::id2addr(ready_head_q);
          state_d    = S_WALK;
        end
      end

      // link_rd is the successor of walk_p_q
      S_WALK: begin
        if (link_rd == cur_id_q) begin
          ram_we    = 1'b1;
          ram_waddr = plsm_pkg::id2addr(walk_p_q);
          ram_wdata = succ_q;
          if (ready_tail_q == cur_id_q) begin
            ready_tail_d = walk_p_q;
          end
          state_d = S_UNLINK;
        end else begin
          walk_p_d   = link_rd;
          walk_cnt_d = walk_cnt_q + CntW'(1);
          if (walk_cnt_q == CntW'(POOL - 1) || !plsm_pkg::id_ok(link_rd)) begin
            state_d = S_UNLINK;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = plsm_pkg::id2addr(link_rd);
          end
        end
      end

      S_UNLINK: begin
        ram_we    = 1'b1;
        ram_waddr = plsm_pkg::id2addr(cur_id_q);
        ram_wdata = '0;
        case (op_q)
          plsm_pkg::OP_CREATE: begin
            tag_d[plsm_pkg::id2addr(cur_id_q)] = plsm_pkg::TAG_READY;
            free_cnt_d  = free_cnt_q - CntW'(1);
            ready_cnt_d = ready_cnt_q + CntW'(1);
            granted_d   = cur_id_q;
          end
          plsm_pkg::OP_KILL: begin
            tag_d[plsm_pkg::id2addr(cur_id_q)] = plsm_pkg::TAG_FREE;
            ready_cnt_d = ready_cnt_q - CntW'(1);
            free_cnt_d  = free_cnt_q + CntW'(1);
          end
          default: begin
            tag_d[plsm_pkg::id2addr(cur_id_q)] = plsm_pkg::TAG_BLOCKED;
            ready_cnt_d = ready_cnt_q - CntW'(1);
            blk_cnt_d   = blk_cnt_q + CntW'(1);
          end
        endcase
        if (dst_head == '0 || !plsm_pkg::id_ok(dst_tail)) begin
          set_dst_head = 1'b1;
          set_dst_tail = 1'b1;
          state_d      = S_DONE;
        end else begin
          state_d = S_LINK;
        end
      end

      S_LINK: begin
        ram_we       = 1'b1;
        ram_waddr    = plsm_pkg::id2addr(dst_tail);
        ram_wdata    = cur_id_q;
        set_dst_tail = 1'b1;
        state_d      = S_DONE;
      end

      S_DONE: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (set_dst_head || set_dst_tail) begin
      case (op_q)
        plsm_pkg::OP_CREATE: begin
          if (set_dst_head) ready_head_d = cur_id_q;
          if (set_dst_tail) ready_tail_d = cur_id_q;
        end
        plsm_pkg::OP_KILL: begin
          if (set_dst_head) free_head_d = cur_id_q;
          if (set_dst_tail) free_tail_d = cur_id_q;
        end
        default: begin
          if (set_dst_head) blk_head_d = cur_id_q;
          if (set_dst_tail) blk_tail_d = cur_id_q;
        end
      endcase
    end

    if (ram_we) begin
      link_vld_d[ram_waddr] = 1'b1;
    end
    if (ram_re) begin
      rd_addr_d = ram_raddr;
      rd_vld_d  = link_vld_q[ram_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      free_head_q  <= IdW'(1);
      free_tail_q  <= IdW'(POOL);
      ready_head_q <= '0;
      ready_tail_q <= '0;
      blk_head_q   <= '0;
      blk_tail_q   <= '0;
      free_cnt_q   <= CntW'(POOL);
      ready_cnt_q  <= '0;
      blk_cnt_q    <= '0;
      link_vld_q   <= '0;
      for (int i = 0; i < POOL; i++) begin
        tag_q[i] <= plsm_pkg::TAG_FREE;
      end
    end else begin
      state_q      <= state_d;
      free_head_q  <= free_head_d;
      free_tail_q  <= free_tail_d;
      ready_head_q <= ready_head_d;
      ready_tail_q <= ready_tail_d;
      blk_head_q   <= blk_head_d;
      blk_tail_q   <= blk_tail_d;
      free_cnt_q   <= free_cnt_d;
      ready_cnt_q  <= ready_cnt_d;
      blk_cnt_q    <= blk_cnt_d;
      link_vld_q   <= link_vld_d;
      tag_q        <= tag_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    cur_id_q   <= cur_id_d;
    succ_q     <= succ_d;
    walk_p_q   <= walk_p_d;
    walk_cnt_q <= walk_cnt_d;
    status_q   <= status_d;
    granted_q  <= granted_d;
    rd_addr_q  <= rd_addr_d;
    rd_vld_q   <= rd_vld_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_DONE);

  assign out_data_o.status      = status_q;
  assign out_data_o.granted_id  = granted_q;
  assign out_data_o.free_len    = free_cnt_q;
  assign out_data_o.ready_len   = ready_cnt_q;
  assign out_data_o.blocked_len = blk_cnt_q;

  logic [CntW+1:0] cnt_sum;
  assign cnt_sum = (CntW+2)'(free_cnt_q) + (CntW+2)'(ready_cnt_q) + (CntW+2)'(blk_cnt_q);

  `ASSERT_CLK(a_cnt_sum, (state_q == S_IDLE) |-> (cnt_sum == (CntW+2)'(POOL)), "list lengths do not add up to the pool")
  `ASSERT_CLK(a_free_empty, (state_q == S_IDLE) |-> ((free_cnt_q == '0) == (free_head_q == '0)), "free count and free head disagree")
  `ASSERT_CLK(a_walk_bound, (state_q == S_WALK) |-> (walk_cnt_q < CntW'(POOL)), "ready walk ran past the pool size")
  `ASSERT_CLK(a_grant, (out_valid_o && granted_q != '0) |-> (status_q == plsm_pkg::ST_DONE && op_q == plsm_pkg::OP_CREATE && tag_q[plsm_pkg::id2addr(granted_q)] == plsm_pkg::TAG_READY), "granted id is not a ready create")

endmodule
